@@ rtl/glp_pkg.sv @@
`timescale 1ns / 1ps
`default_nettype none

package glp_pkg;

    // Kind of an input item, carried on the input tuser bit.
    localparam logic REQ_CHAR = 1'b0;
    localparam logic REQ_EOL  = 1'b1;

    // Character codes the parser reacts to.
    localparam logic [7:0] CH_SPACE    = 8'h20;
    localparam logic [7:0] CH_TAB      = 8'h09;
    localparam logic [7:0] CH_CR       = 8'h0D;
    localparam logic [7:0] CH_SEMI     = 8'h3B;
    localparam logic [7:0] CH_LPAREN   = 8'h28;
    localparam logic [7:0] CH_DOT      = 8'h2E;
    localparam logic [7:0] CH_MINUS    = 8'h2D;
    localparam logic [7:0] CH_ZERO     = 8'h30;
    localparam logic [7:0] CH_NINE     = 8'h39;
    localparam logic [7:0] CH_G        = 8'h47;
    localparam logic [7:0] CH_X        = 8'h58;
    localparam logic [7:0] CH_Y        = 8'h59;
    localparam logic [7:0] CH_Z        = 8'h5A;
    localparam logic [7:0] CH_F        = 8'h46;
    localparam logic [7:0] CH_LOWER_A  = 8'h61;
    localparam logic [7:0] CH_LOWER_Z  = 8'h7A;
    localparam logic [7:0] CASE_OFFSET = 8'h20;

    // G number handling.
    localparam int unsigned   CODE_WIDTH = 14;
    localparam logic [13:0]   CODE_MAX   = 14'd9999;
    localparam logic [13:0]   CODE_LAST_MOTION = 14'd4;
    localparam logic [13:0]   CODE_INCH  = 14'd20;
    localparam logic [13:0]   CODE_MM    = 14'd21;
    localparam logic [13:0]   CODE_ABS   = 14'd90;
    localparam logic [13:0]   CODE_REL   = 14'd91;

    // Power of ten, used on elaboration-time arguments only.
    function automatic logic [63:0] pow10(input int n);
        logic [63:0] p;
        p = 64'd1;
        for (int i = 0; i < n; i++)
        begin
            p = p * 64'd10;
        end
        return p;
    endfunction

endpackage

`default_nettype wire

@@ rtl/glp_fixed_value.sv @@
`timescale 1ns / 1ps
`default_nettype none

// Turns an integer part, a fraction part and a sign into a saturated
// two's complement fixed-point value.
module glp_fixed_value
    import glp_pkg::*;
#(
    parameter int FRACTION_DIGITS = 3,
    parameter int VALUE_WIDTH     = 32
)
(
    input  wire logic [$clog2((64'd1 << (VALUE_WIDTH - 1)) / pow10(FRACTION_DIGITS)
                             + 64'd2) - 1:0] int_accum,
    input  wire logic [$clog2(pow10(FRACTION_DIGITS)) - 1:0] frac_accum,
    input  wire logic                     negative,
    output logic      [VALUE_WIDTH - 1:0] value
);

    localparam logic [63:0] VAL_LIMIT = 64'd1 << (VALUE_WIDTH - 1);
    localparam logic [63:0] SCALE     = pow10(FRACTION_DIGITS);
    localparam logic [63:0] INT_CAP   = VAL_LIMIT / SCALE + 64'd1;
    localparam int          IW        = $clog2(INT_CAP + 64'd1);
    localparam int          MW        = VALUE_WIDTH + 1;

    logic [MW-1:0] product;
    logic [MW-1:0] magnitude;
    logic [MW-1:0] limit;
    logic [MW-1:0] clipped;
    logic [MW-1:0] negated;
    logic          too_big;

    assign product   = MW'(int_accum) * MW'(SCALE);
    assign magnitude = product + MW'(frac_accum);
    assign limit     = MW'(VAL_LIMIT);
    assign too_big   = (int_accum >= IW'(INT_CAP));

    always_comb
    begin
        if (negative)
        begin
            clipped = (too_big || magnitude > limit) ? limit : magnitude;
        end
        else
        begin
            clipped = (too_big || magnitude > limit - MW'(1)) ? limit - MW'(1) : magnitude;
        end
        negated = MW'(0) - clipped;
        value   = negative ? negated[VALUE_WIDTH-1:0] : clipped[VALUE_WIDTH-1:0];
    end

endmodule

`default_nettype wire

@@ rtl/gcode_line_field_parser.sv @@
`timescale 1ns / 1ps
`default_nettype none

// An end of line is held in the input register, its result in the output register.
// Throughput: one input transfer per cycle, characters and end-of-line items alike;
// an end-of-line item waits only while the single output register is still full.
// Reset: rst_n clears asynchronously the line state, both valid flags and the four
// stored axis values; the block takes input from the first cycle after reset.
module gcode_line_field_parser
    import glp_pkg::*;
#(
    parameter int FRACTION_DIGITS = 3,
    parameter int VALUE_WIDTH     = 32
)
(
    input  wire logic        clk,
    input  wire logic        rst_n,

    // Input stream: one transfer per character or end of line.
    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire logic [7:0]  s_tdata,   // [7:0] char_code
    input  wire logic        s_tuser,   // [0] req_type (0 = character, 1 = end of line)

    // Result stream: one transfer per line.
    output logic             m_tvalid,
    input  wire logic        m_tready,
    // From bit 0 up: accepted, g_code (14), x_value, y_value, z_value, feed_value
    // (VALUE_WIDTH each, two's complement), then zero fill to whole bytes.
    output logic [((15 + 4 * VALUE_WIDTH + 7) / 8) * 8 - 1:0] m_tdata
);

    // Number formats. The integer part is held up to a cap just above what can
    // still fit once scaled; the fraction part holds FRACTION_DIGITS digits.
    localparam logic [63:0] VAL_LIMIT = 64'd1 << (VALUE_WIDTH - 1);
    localparam logic [63:0] SCALE     = pow10(FRACTION_DIGITS);
    localparam logic [63:0] INT_CAP   = VAL_LIMIT / SCALE + 64'd1;
    localparam int          IW        = $clog2(INT_CAP + 64'd1);
    localparam int          FW        = $clog2(SCALE);
    localparam int          CW        = $clog2(FRACTION_DIGITS + 1);
    localparam int          OUT_W     = ((15 + 4 * VALUE_WIDTH + 7) / 8) * 8;
    localparam int          PAD_W     = OUT_W - 15 - 4 * VALUE_WIDTH;

    // Which word the current number belongs to.
    typedef enum logic [2:0] {
        T_NONE,
        T_G,
        T_X,
        T_Y,
        T_Z,
        T_F
    } target_t;

    // Where the reader stands inside an axis number.
    typedef enum logic [2:0] {
        PH_IDLE,
        PH_START,
        PH_SIGN,
        PH_INT,
        PH_DOT0,
        PH_FRAC
    } phase_t;

    // Input register.
    logic                     in_valid_reg, in_valid_next;
    logic                     in_type_reg;
    logic [7:0]               in_char_reg;

    // Line state.
    logic                     seen_nonspace_reg, seen_nonspace_next;
    logic                     comment_line_reg, comment_line_next;
    logic [4:0]               letters_seen_reg, letters_seen_next;
    target_t                  target_reg, target_next;
    phase_t                   phase_reg, phase_next;
    logic                     negative_reg, negative_next;
    logic [IW-1:0]            int_accum_reg, int_accum_next;
    logic [FW-1:0]            frac_accum_reg, frac_accum_next;
    logic [CW-1:0]            frac_count_reg, frac_count_next;
    logic [CODE_WIDTH-1:0]    code_accum_reg, code_accum_next;
    logic [VALUE_WIDTH-1:0]   axis_reg [4];
    logic [VALUE_WIDTH-1:0]   axis_next [4];

    // Output register.
    logic                     m_valid_reg, m_valid_next;
    logic [OUT_W-1:0]         m_tdata_reg, m_tdata_next;

    // Handshake. A character never needs the output side, so only an end of
    // line waits for room in the output register.
    logic                     out_free;
    logic                     proceed;
    logic                     in_take;

    assign out_free = !m_valid_reg || m_tready;
    assign proceed  = in_valid_reg && ((in_type_reg == REQ_CHAR) || out_free);
    assign s_tready = !in_valid_reg || proceed;
    assign in_take  = s_tvalid && s_tready;
    assign m_tvalid = m_valid_reg;
    assign m_tdata  = m_tdata_reg;

    // Character classification on the folded character.
    logic [7:0]               ch;
    logic                     is_space;
    logic                     is_digit;
    logic [3:0]               digit;
    logic                     opens_comment;
    logic                     skip_char;
    logic                     is_axis;
    logic [1:0]               axis_idx;
    logic [VALUE_WIDTH-1:0]   fin_value;

    always_comb
    begin
        if (in_char_reg >= CH_LOWER_A && in_char_reg <= CH_LOWER_Z)
        begin
            ch = in_char_reg - CASE_OFFSET;
        end
        else
        begin
            ch = in_char_reg;
        end
    end

    assign is_space      = (ch == CH_SPACE) || (ch >= CH_TAB && ch <= CH_CR);
    assign is_digit      = (ch >= CH_ZERO) && (ch <= CH_NINE);
    assign digit         = 4'(ch - CH_ZERO);
    assign opens_comment = !seen_nonspace_reg && ((ch == CH_SEMI) || (ch == CH_LPAREN));
    assign skip_char     = comment_line_reg || (!seen_nonspace_reg && is_space);
    assign is_axis       = (target_reg != T_NONE) && (target_reg != T_G);
    assign axis_idx      = 2'(target_reg - T_X);

    // The number being read, closed out as a saturated fixed-point value. The
    // same unit serves a number ended by a character and one ended by the line.
    glp_fixed_value #(
        .FRACTION_DIGITS (FRACTION_DIGITS),
        .VALUE_WIDTH     (VALUE_WIDTH)
    ) u_fix (
        .int_accum  (int_accum_reg),
        .frac_accum (frac_accum_reg),
        .negative   (negative_reg),
        .value      (fin_value)
    );

    // Digit steps: multiply by ten as two shifts and an add, then clamp.
    logic [IW+3:0]            int_wide;
    logic [IW-1:0]            int_stepped;
    logic [CODE_WIDTH+3:0]    code_wide;
    logic [CODE_WIDTH-1:0]    code_stepped;
    logic [FW-1:0]            frac_weight;
    logic [FW+3:0]            frac_add;

    always_comb
    begin
        int_wide    = ((IW + 4)'(int_accum_reg) << 3) + ((IW + 4)'(int_accum_reg) << 1)
                      + (IW + 4)'(digit);
        int_stepped = (int_wide > (IW + 4)'(INT_CAP)) ? IW'(INT_CAP) : int_wide[IW-1:0];

        code_wide    = ((CODE_WIDTH + 4)'(code_accum_reg) << 3)
                       + ((CODE_WIDTH + 4)'(code_accum_reg) << 1)
                       + (CODE_WIDTH + 4)'(digit);
        code_stepped = (code_wide > (CODE_WIDTH + 4)'(CODE_MAX)) ? CODE_MAX
                                                                 : code_wide[CODE_WIDTH-1:0];

        // Weight of the next fraction digit: the first one counts
        // 10^(FRACTION_DIGITS-1), the last one counts 1.
        frac_weight = '0;
        for (int i = 0; i < FRACTION_DIGITS; i++)
        begin
            if (frac_count_reg == CW'(i))
            begin
                frac_weight = FW'(pow10(FRACTION_DIGITS - 1 - i));
            end
        end
        frac_add = (FW + 4)'(frac_weight) * (FW + 4)'(digit);
    end

    // Letter decode for the words that start a number.
    target_t                  letter_tgt;
    logic [4:0]               letter_bit;

    always_comb
    begin
        unique case (ch)
            CH_G:
            begin
                letter_tgt = T_G;
                letter_bit = 5'b00001;
            end
            CH_X:
            begin
                letter_tgt = T_X;
                letter_bit = 5'b00010;
            end
            CH_Y:
            begin
                letter_tgt = T_Y;
                letter_bit = 5'b00100;
            end
            CH_Z:
            begin
                letter_tgt = T_Z;
                letter_bit = 5'b01000;
            end
            CH_F:
            begin
                letter_tgt = T_F;
                letter_bit = 5'b10000;
            end
            default:
            begin
                letter_tgt = T_NONE;
                letter_bit = 5'b00000;
            end
        endcase
    end

    // Values seen at the end of a line: the number still open is closed here.
    logic [VALUE_WIDTH-1:0]   eol_val [4];
    logic                     code_ok;

    always_comb
    begin
        for (int k = 0; k < 4; k++)
        begin
            eol_val[k] = (is_axis && axis_idx == 2'(k)) ? fin_value : axis_reg[k];
        end
    end

    assign code_ok = (code_accum_reg <= CODE_LAST_MOTION) || (code_accum_reg == CODE_INCH)
                     || (code_accum_reg == CODE_MM) || (code_accum_reg == CODE_ABS)
                     || (code_accum_reg == CODE_REL);

    // Next line state and result.
    logic                     consumed;
    logic                     finish;

    always_comb
    begin
        seen_nonspace_next = seen_nonspace_reg;
        comment_line_next  = comment_line_reg;
        letters_seen_next  = letters_seen_reg;
        target_next        = target_reg;
        phase_next         = phase_reg;
        negative_next      = negative_reg;
        int_accum_next     = int_accum_reg;
        frac_accum_next    = frac_accum_reg;
        frac_count_next    = frac_count_reg;
        code_accum_next    = code_accum_reg;
        for (int k = 0; k < 4; k++)
        begin
            axis_next[k] = axis_reg[k];
        end
        m_tdata_next = m_tdata_reg;
        consumed     = 1'b0;
        finish       = 1'b0;

        if (proceed && in_type_reg == REQ_EOL)
        begin
            if (!seen_nonspace_reg || comment_line_reg)
            begin
                // Empty, blank or comment line: accepted with nothing in it.
                m_tdata_next = OUT_W'(1);
            end
            else
            begin
                m_tdata_next = {{PAD_W{1'b0}}, eol_val[3], eol_val[2], eol_val[1],
                                eol_val[0], code_accum_reg, code_ok};
            end
            seen_nonspace_next = 1'b0;
            comment_line_next  = 1'b0;
            letters_seen_next  = '0;
            target_next        = T_NONE;
            phase_next         = PH_IDLE;
            negative_next      = 1'b0;
            int_accum_next     = '0;
            frac_accum_next    = '0;
            frac_count_next    = '0;
            code_accum_next    = '0;
            for (int k = 0; k < 4; k++)
            begin
                axis_next[k] = '0;
            end
        end
        else if (proceed && !skip_char)
        begin
            seen_nonspace_next = 1'b1;
            if (opens_comment)
            begin
                comment_line_next = 1'b1;
            end
            else
            begin
                if (target_reg == T_G)
                begin
                    if (is_digit)
                    begin
                        code_accum_next = code_stepped;
                        consumed        = 1'b1;
                    end
                    else
                    begin
                        finish = 1'b1;
                    end
                end
                else if (is_axis)
                begin
                    if (is_digit)
                    begin
                        consumed = 1'b1;
                        unique case (phase_reg) inside
                            PH_START, PH_SIGN:
                            begin
                                phase_next     = PH_INT;
                                int_accum_next = IW'(digit);
                            end
                            PH_INT:
                            begin
                                int_accum_next = int_stepped;
                            end
                            default:
                            begin
                                // Digits past the last fraction place are dropped.
                                phase_next = PH_FRAC;
                                if (frac_count_reg < CW'(FRACTION_DIGITS))
                                begin
                                    frac_accum_next = frac_accum_reg + frac_add[FW-1:0];
                                    frac_count_next = frac_count_reg + CW'(1);
                                end
                            end
                        endcase
                    end
                    else if (ch == CH_DOT)
                    begin
                        consumed = 1'b1;
                        if (phase_reg == PH_START || phase_reg == PH_SIGN)
                        begin
                            phase_next = PH_DOT0;
                        end
                        else if (phase_reg == PH_INT)
                        begin
                            phase_next = PH_FRAC;
                        end
                        else
                        begin
                            finish = 1'b1;
                        end
                    end
                    else if (ch == CH_MINUS)
                    begin
                        consumed = 1'b1;
                        if (phase_reg == PH_START)
                        begin
                            phase_next    = PH_SIGN;
                            negative_next = 1'b1;
                        end
                        else
                        begin
                            finish = 1'b1;
                        end
                    end
                    else
                    begin
                        finish = 1'b1;
                    end
                end

                if (finish)
                begin
                    if (is_axis)
                    begin
                        axis_next[axis_idx] = fin_value;
                    end
                    target_next = T_NONE;
                    phase_next  = PH_IDLE;
                end

                // Only the first copy of each letter opens a number; a repeat
                // merely closed the one before it.
                if (!consumed && letter_tgt != T_NONE
                    && (letters_seen_reg & letter_bit) == 5'b00000)
                begin
                    letters_seen_next = letters_seen_reg | letter_bit;
                    target_next       = letter_tgt;
                    phase_next        = PH_START;
                    negative_next     = 1'b0;
                    int_accum_next    = '0;
                    frac_accum_next   = '0;
                    frac_count_next   = '0;
                end
            end
        end
    end

    always_comb
    begin
        if (in_take)
        begin
            in_valid_next = 1'b1;
        end
        else if (proceed)
        begin
            in_valid_next = 1'b0;
        end
        else
        begin
            in_valid_next = in_valid_reg;
        end

        if (proceed && in_type_reg == REQ_EOL)
        begin
            m_valid_next = 1'b1;
        end
        else if (m_tready)
        begin
            m_valid_next = 1'b0;
        end
        else
        begin
            m_valid_next = m_valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg      <= 1'b0;
            m_valid_reg       <= 1'b0;
            seen_nonspace_reg <= 1'b0;
            comment_line_reg  <= 1'b0;
            letters_seen_reg  <= '0;
            target_reg        <= T_NONE;
            phase_reg         <= PH_IDLE;
            negative_reg      <= 1'b0;
            int_accum_reg     <= '0;
            frac_accum_reg    <= '0;
            frac_count_reg    <= '0;
            code_accum_reg    <= '0;
            for (int k = 0; k < 4; k++)
            begin
                axis_reg[k] <= '0;
            end
        end
        else
        begin
            in_valid_reg      <= in_valid_next;
            m_valid_reg       <= m_valid_next;
            seen_nonspace_reg <= seen_nonspace_next;
            comment_line_reg  <= comment_line_next;
            letters_seen_reg  <= letters_seen_next;
            target_reg        <= target_next;
            phase_reg         <= phase_next;
            negative_reg      <= negative_next;
            int_accum_reg     <= int_accum_next;
            frac_accum_reg    <= frac_accum_next;
            frac_count_reg    <= frac_count_next;
            code_accum_reg    <= code_accum_next;
            for (int k = 0; k < 4; k++)
            begin
                axis_reg[k] <= axis_next[k];
            end
        end
    end

    // Payload registers carry no reset.
    always_ff @(posedge clk)
    begin
        if (in_take)
        begin
            in_type_reg <= s_tuser;
            in_char_reg <= s_tdata;
        end
        m_tdata_reg <= m_tdata_next;
    end

`ifndef SYNTHESIS
    // A comment line can only have been recognized at its first non-space character.
    a_comment_needs_text: assert property (@(posedge clk) disable iff (!rst_n)
        comment_line_reg |-> seen_nonspace_reg)
        else $error("comment line flagged before any text");

    // A number is being read exactly when some word owns it.
    a_target_phase: assert property (@(posedge clk) disable iff (!rst_n)
        (target_reg == T_NONE) == (phase_reg == PH_IDLE))
        else $error("number phase and target disagree");

    // The G number never passes its saturation point.
    a_code_range: assert property (@(posedge clk) disable iff (!rst_n)
        code_accum_reg <= CODE_MAX)
        else $error("G number above its limit");

    // Closing a line leaves the parser clean and a result waiting.
    a_eol_clears: assert property (@(posedge clk) disable iff (!rst_n)
        (proceed && in_type_reg == REQ_EOL) |=>
        (m_valid_reg && !seen_nonspace_reg && letters_seen_reg == 5'b00000
         && target_reg == T_NONE))
        else $error("line state not cleared after end of line");
`endif

endmodule

`default_nettype wire

@@ bench/tb_gcode_line_field_parser.sv @@
`timescale 1ns / 1ps

module tb_gcode_line_field_parser;
    import glp_pkg::*;

    localparam int          FRAC_DIGITS = 3;
    localparam int          VALUE_BITS  = 32;
    localparam int          OUT_BITS    = ((15 + 4 * VALUE_BITS + 7) / 8) * 8;
    localparam int          WATCH_LIMIT = 3000;
    localparam int          HOLD_CYCLES = 250;
    localparam int          PHASE_ITEMS = 160;

    // Fixed-point limits: magnitude ceiling, scale of one unit and the integer cap.
    localparam longint unsigned FULL_SCALE = 64'd1 << (VALUE_BITS - 1);
    localparam longint unsigned UNIT_SCALE = 64'd1000;
    localparam longint unsigned INT_CEIL   = FULL_SCALE / UNIT_SCALE + 64'd1;

    typedef enum logic [2:0] { WORD_NONE, WORD_G, WORD_X, WORD_Y, WORD_Z, WORD_F } word_t;
    typedef enum logic [2:0] {
        NUM_IDLE, NUM_START, NUM_SIGN, NUM_INT, NUM_LEAD_DOT, NUM_FRAC
    } num_state_t;

    typedef struct packed {
        logic       eol;
        logic [7:0] code;
    } stream_item_t;

    // Same layout as m_tdata from bit 0 up.
    typedef struct packed {
        logic [31:0] feed;
        logic [31:0] z;
        logic [31:0] y;
        logic [31:0] x;
        logic [13:0] g_code;
        logic        accepted;
    } line_result_t;

    logic                clk = 1'b0;
    logic                rst_n = 1'b0;
    logic                s_tvalid = 1'b0;
    logic                s_tready;
    logic [7:0]          s_tdata = 8'h00;
    logic                s_tuser = 1'b0;
    logic                m_tvalid;
    logic                m_tready = 1'b0;
    logic [OUT_BITS-1:0] m_tdata;

    gcode_line_field_parser dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    always #6 clk = ~clk;

    stream_item_t char_stream[$];
    line_result_t expected_lines[$];

    int  send_idle_pct = 0;
    int  recv_stall_pct = 0;
    bit  pressure_go = 1'b0;
    logic rx_hold = 1'b0;
    int  err_count = 0;
    int  queued_items = 0;
    int  chars_sent = 0;
    int  lines_sent = 0;
    int  lines_checked = 0;
    int  lines_accepted = 0;
    int  input_stall_cycles = 0;
    int  quiet_cycles = 0;

    // Parser state of the predictor, mirrored per line.
    bit              line_started;
    bit              line_is_comment;
    bit [4:0]        words_taken;
    word_t           cur_word;
    num_state_t      num_state;
    bit              num_neg;
    longint unsigned int_part;
    longint unsigned frac_part;
    int              frac_count;
    int unsigned     g_accum;
    logic [31:0]     axis_word[4];

    task automatic flag_mismatch(input string what);
        err_count++;
        if (err_count <= 40)
            $display("MISMATCH at line result %0d: %s", lines_checked, what);
    endtask

    task automatic clear_line_state();
        line_started    = 1'b0;
        line_is_comment = 1'b0;
        words_taken     = '0;
        cur_word        = WORD_NONE;
        num_state       = NUM_IDLE;
        num_neg         = 1'b0;
        int_part        = 0;
        frac_part       = 0;
        frac_count      = 0;
        g_accum         = 0;
        for (int i = 0; i < 4; i++)
        begin
            axis_word[i] = '0;
        end
    endtask

    // Closes whatever word is open; X/Y/Z/F values are scaled and saturated here.
    function automatic void close_word_number();
        longint unsigned mag;
        longint unsigned val;
        if (cur_word >= WORD_X && cur_word <= WORD_F)
        begin
            if (int_part >= INT_CEIL)
                mag = FULL_SCALE;
            else
                mag = int_part * UNIT_SCALE + frac_part;
            if (num_neg)
            begin
                if (mag > FULL_SCALE)
                    mag = FULL_SCALE;
                val = 64'd0 - mag;
            end
            else
            begin
                if (mag > FULL_SCALE - 1)
                    mag = FULL_SCALE - 1;
                val = mag;
            end
            axis_word[cur_word - WORD_X] = val[31:0];
        end
        cur_word  = WORD_NONE;
        num_state = NUM_IDLE;
    endfunction

    // One character inside an axis number; returns 1 when it belonged to the number text.
    function automatic bit number_text_char(input logic [7:0] c);
        longint unsigned digit;
        longint unsigned weight;
        digit = c - CH_ZERO;
        if (c >= CH_ZERO && c <= CH_NINE)
        begin
            if (num_state == NUM_START || num_state == NUM_SIGN)
            begin
                num_state = NUM_INT;
                int_part  = digit;
            end
            else if (num_state == NUM_INT)
            begin
                int_part = int_part * 10 + digit;
                if (int_part > INT_CEIL)
                    int_part = INT_CEIL;
            end
            else
            begin
                num_state = NUM_FRAC;
                if (frac_count < FRAC_DIGITS)
                begin
                    weight = 1;
                    for (int i = frac_count + 1; i < FRAC_DIGITS; i++)
                    begin
                        weight = weight * 10;
                    end
                    frac_part  = frac_part + digit * weight;
                    frac_count = frac_count + 1;
                end
            end
            return 1'b1;
        end
        if (c == CH_DOT)
        begin
            if (num_state == NUM_START || num_state == NUM_SIGN)
                num_state = NUM_LEAD_DOT;
            else if (num_state == NUM_INT)
                num_state = NUM_FRAC;
            else
                close_word_number();
            return 1'b1;
        end
        if (c == CH_MINUS)
        begin
            if (num_state == NUM_START)
            begin
                num_state = NUM_SIGN;
                num_neg   = 1'b1;
            end
            else
            begin
                close_word_number();
            end
            return 1'b1;
        end
        return 1'b0;
    endfunction

    task automatic parse_char(input logic [7:0] raw);
        logic [7:0] c;
        word_t      target;
        bit [4:0]   mask;
        c = raw;
        target = WORD_NONE;
        if (c >= CH_LOWER_A && c <= CH_LOWER_Z)
            c = c - CASE_OFFSET;
        if (line_is_comment)
            return;
        if (!line_started)
        begin
            if (c == CH_SPACE || (c >= CH_TAB && c <= CH_CR))
                return;
            line_started = 1'b1;
            if (c == CH_SEMI || c == CH_LPAREN)
            begin
                line_is_comment = 1'b1;
                return;
            end
        end
        if (cur_word == WORD_G)
        begin
            if (c >= CH_ZERO && c <= CH_NINE)
            begin
                g_accum = g_accum * 10 + (c - CH_ZERO);
                if (g_accum > CODE_MAX)
                    g_accum = CODE_MAX;
                return;
            end
            close_word_number();
        end
        else if (cur_word != WORD_NONE)
        begin
            if (number_text_char(c))
                return;
            close_word_number();
        end
        case (c)
            CH_G:    target = WORD_G;
            CH_X:    target = WORD_X;
            CH_Y:    target = WORD_Y;
            CH_Z:    target = WORD_Z;
            CH_F:    target = WORD_F;
            default: target = WORD_NONE;
        endcase
        if (target == WORD_NONE)
            return;
        // Only the first copy of each letter opens a word.
        mask = 5'd1 << (target - 1);
        if ((words_taken & mask) != 0)
            return;
        words_taken = words_taken | mask;
        cur_word    = target;
        num_state   = NUM_START;
        num_neg     = 1'b0;
        int_part    = 0;
        frac_part   = 0;
        frac_count  = 0;
    endtask

    task automatic parse_line_end(output line_result_t res);
        res = '0;
        if (!line_started || line_is_comment)
        begin
            res.accepted = 1'b1;
        end
        else
        begin
            close_word_number();
            res.accepted = (g_accum <= CODE_LAST_MOTION) || (g_accum == CODE_INCH) ||
                           (g_accum == CODE_MM) || (g_accum == CODE_ABS) ||
                           (g_accum == CODE_REL);
            res.g_code = g_accum[13:0];
            res.x      = axis_word[0];
            res.y      = axis_word[1];
            res.z      = axis_word[2];
            res.feed   = axis_word[3];
        end
        clear_line_state();
    endtask

    task automatic push_item(input logic eol, input logic [7:0] code);
        stream_item_t it;
        it.eol  = eol;
        it.code = code;
        char_stream.push_back(it);
        queued_items++;
    endtask

    task automatic push_text(input string s);
        for (int i = 0; i < s.len(); i++)
        begin
            push_item(REQ_CHAR, s[i]);
        end
    endtask

    // A line of text closed by an end-of-line transfer with a random ignored byte.
    task automatic push_line(input string s);
        push_text(s);
        push_item(REQ_EOL, 8'($urandom_range(255)));
    endtask

    task automatic push_digits(input int n);
        for (int i = 0; i < n; i++)
        begin
            push_item(REQ_CHAR, CH_ZERO + 8'($urandom_range(9)));
        end
    endtask

    // One word: a letter and then a plausible number, sometimes broken on purpose.
    task automatic push_random_word();
        string letters;
        string codes[14];
        logic [7:0] letter;
        int r;
        letters = "GGXYZFGXYZFgxyzfMSNT";
        codes = '{"0", "1", "2", "3", "4", "5", "17", "20", "21", "28", "90", "91", "00092",
                  "123456"};
        letter = letters[$urandom_range(letters.len() - 1)];
        push_item(REQ_CHAR, letter);
        if (letter == CH_G || letter == CH_G + CASE_OFFSET)
        begin
            r = $urandom_range(9);
            if (r < 7)
                push_text(codes[$urandom_range(13)]);
            else if (r < 9)
                push_digits($urandom_range(1, 5));
        end
        else
        begin
            if ($urandom_range(99) < 35)
                push_item(REQ_CHAR, CH_MINUS);
            if ($urandom_range(99) < 6)
                push_digits($urandom_range(6, 12));
            else
                push_digits($urandom_range(0, 4));
            if ($urandom_range(99) < 60)
            begin
                push_item(REQ_CHAR, CH_DOT);
                push_digits($urandom_range(0, 5));
            end
            r = $urandom_range(99);
            if (r < 4)
                push_item(REQ_CHAR, CH_MINUS);
            else if (r < 8)
                push_item(REQ_CHAR, CH_DOT);
            else if (r < 10)
                push_text("+");
            if (r < 10)
                push_digits($urandom_range(0, 3));
        end
        if ($urandom_range(99) < 40)
            push_item(REQ_CHAR, CH_SPACE);
    endtask

    task automatic push_random_line();
        int kind;
        kind = $urandom_range(99);
        repeat ($urandom_range(0, 2))
        begin
            if ($urandom_range(1))
                push_item(REQ_CHAR, CH_SPACE);
            else
                push_item(REQ_CHAR, CH_TAB + 8'($urandom_range(4)));
        end
        if (kind < 6)
        begin
            // blank or whitespace-only line
        end
        else if (kind < 14)
        begin
            push_item(REQ_CHAR, $urandom_range(1) ? CH_SEMI : CH_LPAREN);
            repeat ($urandom_range(0, 15))
            begin
                push_item(REQ_CHAR, 8'($urandom_range(255)));
            end
        end
        else if (kind < 22)
        begin
            repeat ($urandom_range(1, 12))
            begin
                push_item(REQ_CHAR, 8'($urandom_range(255)));
            end
        end
        else
        begin
            repeat ($urandom_range(1, 5))
            begin
                push_random_word();
                if ($urandom_range(99) < 5)
                    push_item(REQ_CHAR, 8'($urandom_range(255)));
            end
        end
        push_item(REQ_EOL, 8'($urandom_range(255)));
    endtask

    // Sender: presents queued items, holds them while the parser is not ready, and
    // runs the predictor on every transfer that completes.
    always @(posedge clk)
    begin : drive_input
        stream_item_t next_it;
        line_result_t res;
        if (rst_n)
        begin
            if (s_tvalid && s_tready)
            begin
                if (s_tuser == REQ_EOL)
                begin
                    parse_line_end(res);
                    expected_lines.push_back(res);
                    lines_sent++;
                end
                else
                begin
                    parse_char(s_tdata);
                    chars_sent++;
                end
            end
            if (s_tvalid && !s_tready)
            begin
                input_stall_cycles++;
            end
            else if (char_stream.size() != 0 && $urandom_range(99) >= send_idle_pct)
            begin
                next_it = char_stream.pop_front();
                s_tvalid <= 1'b1;
                s_tdata  <= next_it.code;
                s_tuser  <= next_it.eol;
            end
            else
            begin
                s_tvalid <= 1'b0;
            end
        end
    end

    // Receiver: checks each result transfer against the oldest predicted line.
    always @(posedge clk)
    begin : check_output
        line_result_t got;
        line_result_t want;
        if (rst_n)
        begin
            if (m_tvalid && m_tready)
            begin
                got = m_tdata[$bits(line_result_t)-1:0];
                lines_checked++;
                if (expected_lines.size() == 0)
                begin
                    flag_mismatch("result transfer with no line outstanding");
                end
                else
                begin
                    want = expected_lines.pop_front();
                    if (got.accepted !== want.accepted)
                        flag_mismatch($sformatf("accepted %0d, predicted %0d",
                                                got.accepted, want.accepted));
                    if (got.g_code !== want.g_code)
                        flag_mismatch($sformatf("g_code %0d, predicted %0d",
                                                got.g_code, want.g_code));
                    if (got.x !== want.x)
                        flag_mismatch($sformatf("x_value %0d, predicted %0d",
                                                $signed(got.x), $signed(want.x)));
                    if (got.y !== want.y)
                        flag_mismatch($sformatf("y_value %0d, predicted %0d",
                                                $signed(got.y), $signed(want.y)));
                    if (got.z !== want.z)
                        flag_mismatch($sformatf("z_value %0d, predicted %0d",
                                                $signed(got.z), $signed(want.z)));
                    if (got.feed !== want.feed)
                        flag_mismatch($sformatf("feed_value %0d, predicted %0d",
                                                $signed(got.feed), $signed(want.feed)));
                    if (want.accepted)
                        lines_accepted++;
                end
            end
            m_tready <= !rx_hold && ($urandom_range(99) >= recv_stall_pct);
        end
    end

    // Long receiver hold-off so the output register fills and end-of-line items back up.
    initial
    begin
        wait (pressure_go);
        repeat (20) @(posedge clk);
        rx_hold <= 1'b1;
        repeat (HOLD_CYCLES) @(posedge clk);
        rx_hold <= 1'b0;
    end

    // Ends the run if no transfer happens on either side for too long.
    always @(posedge clk)
    begin
        if (!rst_n || (s_tvalid && s_tready) || (m_tvalid && m_tready))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= WATCH_LIMIT)
        begin
            $display("timeout: no transfer for %0d cycles", WATCH_LIMIT);
            $display("tb_gcode_line_field_parser: done, errors");
            $finish;
        end
    end

    initial
    begin : stimulus
        int phase_end;
        clear_line_state();

        // Directed lines: blank and comment lines, case folding, value extremes,
        // repeated letters, broken number text and bytes outside the letter set.
        push_line("");
        push_line(" \t\r\n\v\f");
        push_line(";G5 X1");
        push_line("  (G1");
        push_line("g1x-1.5y.25z3f100");
        push_line("G21X2147483.647Y-2147483.648");
        push_line("G99999X2147483.648Y-2147483.649Z99999999999F0.0009");
        push_line("GX-.1234Y--5Z1.2.3F+5");
        push_line("G1G2X1X2.5 Y-0");
        push_text("X5");
        push_item(REQ_CHAR, 8'hFF);
        push_text("Y6");
        push_item(REQ_CHAR, 8'h01);
        push_line("Z-.F-");
        push_line("G90");
        push_line("G91");
        push_line("G4");
        push_line("G5");
        push_line("G20");
        push_line("M3 X.");
        push_line(" \tG00003 X-");

        repeat (10) @(posedge clk);
        rst_n <= 1'b1;

        // Phase with no idling, carrying the long receiver hold-off.
        phase_end = queued_items + PHASE_ITEMS;
        pressure_go = 1'b1;
        while (queued_items < phase_end)
            push_random_line();
        while (char_stream.size() != 0)
            @(posedge clk);

        send_idle_pct  = 61;
        recv_stall_pct = 0;
        phase_end = queued_items + PHASE_ITEMS;
        while (queued_items < phase_end)
            push_random_line();
        while (char_stream.size() != 0)
            @(posedge clk);

        send_idle_pct  = 0;
        recv_stall_pct = 61;
        phase_end = queued_items + PHASE_ITEMS;
        while (queued_items < phase_end)
            push_random_line();
        while (char_stream.size() != 0)
            @(posedge clk);

        send_idle_pct  = 38;
        recv_stall_pct = 38;
        phase_end = queued_items + PHASE_ITEMS;
        while (queued_items < phase_end)
            push_random_line();

        while (char_stream.size() != 0 || s_tvalid || expected_lines.size() != 0)
            @(posedge clk);
        repeat (8) @(posedge clk);
        if (expected_lines.size() != 0)
            flag_mismatch($sformatf("%0d predicted lines never came out",
                                    expected_lines.size()));

        $display("Covered %0d characters and %0d lines (%0d accepted), input stalled %0d cycles,",
                 chars_sent, lines_sent, lines_accepted, input_stall_cycles);
        $display("with %0d results checked and %0d mismatches.", lines_checked, err_count);
        if (err_count == 0)
            $display("tb_gcode_line_field_parser: done, clean");
        else
            $display("tb_gcode_line_field_parser: done, errors");
        $finish;
    end

endmodule

@@ filelist.f @@
rtl/glp_pkg.sv
rtl/glp_fixed_value.sv
rtl/gcode_line_field_parser.sv
bench/tb_gcode_line_field_parser.sv
